// File: rtl/cerq_pkg.sv
// Package for the coalescing event ring queue: sizes, operation codes and
// the word types of the command, result and storage entry.
// No dependencies.
package cerq_pkg;

  // The ring wraps by dropping the carry of its pointers, so the depth is a
  // power of two.
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = PtrW + 1;

  localparam logic [1:0] FuncPush     = 2'd0;
  localparam logic [1:0] FuncCoalesce = 2'd1;
  localparam logic [1:0] FuncPop      = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] msg_type;
    logic        msg_header_ok;
    logic [63:0] msg_payload;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        pop_valid;
    logic [31:0] out_type;
    logic        out_header_ok;
    logic [63:0] out_payload;
    logic [4:0]  occupancy;
    logic [31:0] drop_total;
  } result_t;

  typedef struct packed {
    logic [31:0] msg_type;
    logic        msg_header_ok;
    logic [63:0] msg_payload;
  } entry_t;

endpackage

// File: rtl/cerq_store.sv
// Message storage of the queue: one write port and one read port with
// registered read data.
// Depends on cerq_pkg.
module cerq_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [cerq_pkg::PtrW-1:0]  waddr_i,
  input  cerq_pkg::entry_t           wdata_i,
  input  logic [cerq_pkg::PtrW-1:0]  raddr_i,
  output cerq_pkg::entry_t           rdata_o
);

  cerq_pkg::entry_t mem_q [cerq_pkg::QueueDepth];
  cerq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/coalescing_event_ring_queue.sv
// Top level of the coalescing event ring queue: command sequencer, ring
// pointers, coalescing hint and drop counter around the message store.
// Depends on cerq_pkg and cerq_store.
//
//  Channel   Ports                          Handshake
//  --------  -----------------------------  ------------------------------------
//  command   start, busy, cmd_i             word taken when start && !busy
//  result    result_valid_o, res_o          one-cycle strobe, always taken
//  config    cfg_we_i, cfg_wdata_i          mouse_type written when cfg_we_i
//
// Timing: a command word taken in idle is registered and then dispatched. A
// push, a coalesced push of a non-mouse message, an empty pop or the unused
// code finishes in dispatch; a pop first waits in the pop-wait state for the
// registered read of the tail entry. A coalesced mouse push reads the hinted
// entry in the hint-wait state when the hint hits, and otherwise scans the
// held entries from the tail, after the hint read if that entry no longer
// held a mouse message. The next command word can be taken at the same edge
// that takes the result word. The single read port of the store, read once a
// cycle by the scan, paces the scan. Reset clears pointers, counters, hint and
// the mouse-type register; the store itself is never cleared. The receiver of
// result words cannot stall, so busy depends only on the sequencer.
module coalescing_event_ring_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cerq_pkg::item_t      cmd_i,
  output logic                 result_valid_o,
  output cerq_pkg::result_t    res_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i
);

  localparam int unsigned PtrW = cerq_pkg::PtrW;
  localparam int unsigned CntW = cerq_pkg::CntW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_WAIT,
    ST_HINT_WAIT,
    ST_SCAN
  } state_e;

  state_e            state_q, state_d;
  cerq_pkg::item_t   req_q, req_d;
  logic [31:0]       mouse_q, mouse_d;
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [31:0]       drop_q, drop_d;
  logic              hint_vld_q, hint_vld_d;
  logic [PtrW-1:0]   hint_idx_q, hint_idx_d;
  logic [PtrW-1:0]   scan_q, scan_d;
  logic              res_vld_q, res_vld_d;
  cerq_pkg::result_t res_q, res_d;

  // Store ports.
  logic              mem_we;
  logic [PtrW-1:0]   mem_waddr;
  logic [PtrW-1:0]   mem_raddr;
  cerq_pkg::entry_t  mem_wdata;
  cerq_pkg::entry_t  mem_rdata;

  // The one compare unit: checks the incoming message while dispatching and
  // the entry just read from the store in every other state.
  logic [31:0]       cmp_type;
  logic              cmp_hdr;
  logic              is_mouse;

  logic              full;
  logic [PtrW-1:0]   hint_dist;
  logic              hint_live;
  logic [PtrW-1:0]   scan_idx;
  logic [CntW-1:0]   scan_next;
  logic [31:0]       drop_sat;

  logic              do_append;
  logic              set_hint;
  logic              start_scan;
  logic              finish;
  logic              acc;
  logic              pop_hit;

  cerq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cmp_type = (state_q == ST_DISPATCH) ? req_q.msg_type : mem_rdata.msg_type;
  assign cmp_hdr  = (state_q == ST_DISPATCH) ? req_q.msg_header_ok : mem_rdata.msg_header_ok;
  assign is_mouse = cmp_hdr && (cmp_type == mouse_q);

  assign full      = (fill_q == CntW'(cerq_pkg::QueueDepth));
  assign hint_dist = hint_idx_q - rptr_q;
  assign hint_live = ({1'b0, hint_dist} < fill_q);
  assign scan_idx  = rptr_q + scan_q;
  assign scan_next = {1'b0, scan_q} + CntW'(1);
  assign drop_sat  = (drop_q == '1) ? drop_q : drop_q + 32'd1;

  assign mem_wdata.msg_type      = req_q.msg_type;
  assign mem_wdata.msg_header_ok = req_q.msg_header_ok;
  assign mem_wdata.msg_payload   = req_q.msg_payload;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    mouse_d    = cfg_we_i ? cfg_wdata_i : mouse_q;
    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    fill_d     = fill_q;
    drop_d     = drop_q;
    hint_vld_d = hint_vld_q;
    hint_idx_d = hint_idx_q;
    scan_d     = scan_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = wptr_q;
    mem_raddr  = rptr_q;
    do_append  = 1'b0;
    set_hint   = 1'b0;
    start_scan = 1'b0;
    finish     = 1'b0;
    acc        = 1'b0;
    pop_hit    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d   = cmd_i;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (req_q.func)
          cerq_pkg::FuncPush: begin
            do_append = 1'b1;
          end
          cerq_pkg::FuncCoalesce: begin
            if (!is_mouse) begin
              hint_vld_d = 1'b0;
              do_append  = 1'b1;
            end else if (hint_vld_q && hint_live) begin
              mem_raddr = hint_idx_q;
              state_d   = ST_HINT_WAIT;
            end else begin
              hint_vld_d = 1'b0;
              start_scan = 1'b1;
            end
          end
          cerq_pkg::FuncPop: begin
            if (fill_q == '0) begin
              finish = 1'b1;
            end else begin
              mem_raddr = rptr_q;
              state_d   = ST_POP_WAIT;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      ST_HINT_WAIT: begin
        // The hinted entry is still held; it is reused only if it still
        // holds a mouse message under the current mouse type.
        if (is_mouse) begin
          mem_we    = 1'b1;
          mem_waddr = hint_idx_q;
          acc       = 1'b1;
          finish    = 1'b1;
        end else begin
          hint_vld_d = 1'b0;
          start_scan = 1'b1;
        end
      end
      ST_SCAN: begin
        // The entry scan_q places behind the tail was read last cycle.
        if (is_mouse) begin
          mem_we     = 1'b1;
          mem_waddr  = scan_idx;
          hint_vld_d = 1'b1;
          hint_idx_d = scan_idx;
          acc        = 1'b1;
          finish     = 1'b1;
        end else if (scan_next < fill_q) begin
          scan_d    = scan_next[PtrW-1:0];
          mem_raddr = rptr_q + scan_next[PtrW-1:0];
        end else begin
          do_append = 1'b1;
          set_hint  = 1'b1;
        end
      end
      ST_POP_WAIT: begin
        pop_hit = 1'b1;
        if (hint_vld_q && (hint_idx_q == rptr_q)) begin
          hint_vld_d = 1'b0;
        end
        rptr_d = rptr_q + PtrW'(1);
        fill_d = fill_q - CntW'(1);
        finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Start of the scan for the oldest mouse entry, from the tail; an empty ring appends at once and sets the hint.
    if (start_scan) begin
      if (fill_q == '0) begin
        do_append = 1'b1;
        set_hint  = 1'b1;
      end else begin
        mem_raddr = rptr_q;
        scan_d    = '0;
        state_d   = ST_SCAN;
      end
    end

    // Append at the head, or drop and count when the ring is full.
    if (do_append) begin
      finish = 1'b1;
      if (full) begin
        drop_d = drop_sat;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = wptr_q;
        wptr_d    = wptr_q + PtrW'(1);
        fill_d    = fill_q + CntW'(1);
        acc       = 1'b1;
        if (set_hint) begin
          hint_vld_d = 1'b1;
          hint_idx_d = wptr_q;
        end
      end
    end

    if (finish) begin
      state_d             = ST_IDLE;
      res_vld_d           = 1'b1;
      res_d.accepted      = acc;
      res_d.pop_valid     = pop_hit;
      res_d.out_type      = pop_hit ? mem_rdata.msg_type : 32'd0;
      res_d.out_header_ok = pop_hit && mem_rdata.msg_header_ok;
      res_d.out_payload   = pop_hit ? mem_rdata.msg_payload : 64'd0;
      res_d.occupancy     = fill_d;
      res_d.drop_total    = drop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= '0;
      mouse_q    <= '0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      fill_q     <= '0;
      drop_q     <= '0;
      hint_vld_q <= 1'b0;
      hint_idx_q <= '0;
      scan_q     <= '0;
      res_vld_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      mouse_q    <= mouse_d;
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      fill_q     <= fill_d;
      drop_q     <= drop_d;
      hint_vld_q <= hint_vld_d;
      hint_idx_q <= hint_idx_d;
      scan_q     <= scan_d;
      res_vld_q  <= res_vld_d;
      res_q      <= res_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

  // The pointers and the fill count must describe the same ring.
  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == fill_q[PtrW-1:0]
    && fill_q <= CntW'(cerq_pkg::QueueDepth))
    else $error("ring pointers disagree with fill count");

  // A valid hint always names an entry that is still held.
  a_hint_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_vld_q |-> hint_live)
    else $error("hint names an entry outside the queue");

  // The drop counter never goes backward.
  a_drop_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> drop_q >= $past(drop_q))
    else $error("drop counter decreased");

  // A result word never reports both a store and a pop.
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(res_o.accepted && res_o.pop_valid))
    else $error("result reports both a store and a pop");

endmodule
